>>> sv/t2t_pkg.sv
// Shared constants, types and the log table builder for the thermistor converter.
`default_nettype none

package t2t_pkg;

  // Widths fixed by the channel and register fields.
  localparam int SAMPLE_W = 10;
  localparam int TEMP_W   = 18;
  localparam int OHMS_W   = 32;
  localparam int SERIES_W = 20;
  localparam int COEF_W   = 40;
  localparam int COEFC_W  = 32;
  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 2;

  // Default parameter values.
  localparam int ADC_BITS_DEF = 10;
  localparam int LOG_DEPTH_DEF = 256;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 2'd3;

  // Register reset values.
  localparam logic [SERIES_W-1:0] SERIES_RST = 20'd10000;
  localparam logic [COEF_W-1:0]   COEF_A_RST = 40'd284078485700;
  localparam logic [COEF_W-1:0]   COEF_B_RST = 40'd66946163000;
  localparam logic [COEFC_W-1:0]  COEF_C_RST = 32'd56835504;

  // Fixed-point constants.
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
  localparam int LMAG_W = 22;   // |ln R| in Q16 stays below 2^22 for every ADC width
  localparam int DEN_W  = 52;   // signed 1/T in Q48
  localparam int N2_W   = 56;
  localparam logic [N2_W-1:0] CENTI_ONE_Q48 = 56'd100 << 48;
  localparam int Q_W    = 18;
  localparam logic [Q_W-1:0] KELVIN_MAX = 18'd158386;
  localparam logic [Q_W-1:0] CELSIUS_OFFSET = 18'd27315;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 18'd131071;

  // Status that travels beside the data through the pipeline.
  typedef struct packed {
    logic              inv;
    logic              full;
    logic [OHMS_W-1:0] ohms;
  } side_t;

  // Bit-serial log2 of x in Q30, x in [1, 2], used only to build the table.
  function automatic logic [30:0] log2_q30(logic [63:0] x);
    logic [63:0] y;
    logic [30:0] res;
    y = x;
    res = '0;
    if (y >= (64'd1 << 31)) begin
      return ONE_Q30;
    end
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/t2t_if.sv
// Sample and result channel interfaces of the thermistor converter.
`default_nettype none

interface t2t_in_if
  import t2t_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_first;
  logic [SAMPLE_W-1:0] sample_second;
  logic [SAMPLE_W-1:0] sample_third;

  modport source (output valid, output sample_first, output sample_second,
                  output sample_third, input ready);
  modport sink (input valid, input sample_first, input sample_second,
                input sample_third, output ready);
endinterface

interface t2t_out_if
  import t2t_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [OHMS_W-1:0]        resistance_ohms;
  logic                     reading_invalid;

  modport source (output valid, output temperature_centi, output resistance_ohms,
                  output reading_invalid, input ready);
  modport sink (input valid, input temperature_centi, input resistance_ohms,
                input reading_invalid, output ready);
endinterface

`default_nettype wire

>>> sv/thermistor_to_temperature_unit.sv
// Top level: pipelined thermistor divider to Steinhart-Hart temperature converter.
//
//   channel   dir  payload                                              transfer
//   samples   in   sample_first, sample_second, sample_third            valid & ready
//   result    out  temperature_centi, resistance_ohms, reading_invalid  valid & ready
//   cfg       in   cfg_index, cfg_data                                  cfg_write high
//
// One item enters per cycle while the result is not stalled. The resistance divider
// resolves one quotient bit per stage over NUM_W stages and the temperature divider
// one bit per stage over 18 stages.
// Reset clears the valid bits and loads the register defaults.
// A stall at the result freezes every stage at once; ready is low only then.
`default_nettype none

module thermistor_to_temperature_unit
  import t2t_pkg::*;
#(
  parameter int ADC_BITS        = ADC_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = LOG_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  t2t_in_if.sink                    samples,
  t2t_out_if.source                 result,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int SUM_W   = ADC_BITS + 2;
  localparam int NUM_W   = SERIES_W + SUM_W + 16;
  localparam int PW      = $clog2(NUM_W);
  localparam int DEPTH_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int FD_W    = 30 + DEPTH_W;
  localparam int LN_W    = 40;
  localparam int DD_W    = DEN_W - 1;
  localparam logic [SUM_W-1:0] FULL = SUM_W'(3 * ((1 << ADC_BITS) - 1));
  localparam logic signed [LN_W-1:0] LN2_S = LN_W'(LN2_Q30);

  // Log2 table in Q30 over [1, 2], built at elaboration.
  typedef logic [30:0] lrom_t [0:LOG_TABLE_DEPTH];

  function automatic lrom_t build_log_rom();
    lrom_t t;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      t[i] = log2_q30(64'(ONE_Q30) + ((64'(i) << 30) / LOG_TABLE_DEPTH));
    end
    return t;
  endfunction

  localparam lrom_t LOG_ROM = build_log_rom();

  logic adv;

  // Configuration registers.
  logic [SERIES_W-1:0] series_resistance;
  logic [COEF_W-1:0]   coef_a;
  logic [COEF_W-1:0]   coef_b;
  logic [COEFC_W-1:0]  coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance <= SERIES_RST;
      coef_a <= COEF_A_RST;
      coef_b <= COEF_B_RST;
      coef_c <= COEF_C_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SERIES: series_resistance <= cfg_data[SERIES_W-1:0];
        REG_COEF_A: coef_a <= cfg_data[COEF_W-1:0];
        REG_COEF_B: coef_b <= cfg_data[COEF_W-1:0];
        REG_COEF_C: coef_c <= cfg_data[COEFC_W-1:0];
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being drained.
  logic out_v;
  assign adv = !out_v || result.ready;
  assign samples.ready = adv;

  // Stage A: sum of the three readings and the special-case flags.
  logic [ADC_BITS-1:0] s1, s2, s3;
  logic [SUM_W-1:0]    sum_c;
  logic                a_v;
  logic [SUM_W-1:0]    a_s;
  logic                a_zero, a_full;

  always_comb begin
    s1 = ADC_BITS'(samples.sample_first);
    s2 = ADC_BITS'(samples.sample_second);
    s3 = ADC_BITS'(samples.sample_third);
    sum_c = SUM_W'(s1) + SUM_W'(s2) + SUM_W'(s3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s <= sum_c;
      a_zero <= (sum_c == '0);
      a_full <= (sum_c == FULL);
    end
  end

  // Resistance divider: stage 0 loads R1*S*2^16 and F-S, then one bit per stage.
  logic              d1_v   [0:NUM_W];
  logic [SUM_W-1:0]  d1_rem [0:NUM_W];
  logic [NUM_W-1:0]  d1_nq  [0:NUM_W];
  logic [SUM_W-1:0]  d1_dv  [0:NUM_W];
  logic              d1_fnd [0:NUM_W];
  logic [PW-1:0]     d1_p   [0:NUM_W];
  side_t             d1_sd  [0:NUM_W];

  logic [NUM_W-17:0] b_prod;
  assign b_prod = (NUM_W-16)'(series_resistance) * (NUM_W-16)'(a_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
    end else if (adv) begin
      d1_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_nq[0]  <= {b_prod, 16'd0};
      d1_dv[0]  <= FULL - a_s;
      d1_rem[0] <= '0;
      d1_fnd[0] <= 1'b0;
      d1_p[0]   <= '0;
      d1_sd[0]  <= '{inv: a_zero | a_full, full: a_full, ohms: '0};
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div1
    logic [SUM_W:0]   trial;
    logic             ge;
    logic [SUM_W-1:0] rem_next;

    always_comb begin
      trial = {d1_rem[k], d1_nq[k][NUM_W-1]};
      ge = (trial >= {1'b0, d1_dv[k]});
      rem_next = ge ? SUM_W'(trial - {1'b0, d1_dv[k]}) : SUM_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[k+1] <= 1'b0;
      end else if (adv) begin
        d1_v[k+1] <= d1_v[k];
      end
    end

    // The first set quotient bit marks the leading-one position.
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_rem[k+1] <= rem_next;
        d1_nq[k+1]  <= {d1_nq[k][NUM_W-2:0], ge};
        d1_dv[k+1]  <= d1_dv[k];
        d1_fnd[k+1] <= d1_fnd[k] | ge;
        d1_p[k+1]   <= (!d1_fnd[k] && ge) ? PW'(NUM_W - 1 - k) : d1_p[k];
        d1_sd[k+1]  <= d1_sd[k];
      end
    end
  end

  // Stage N: rounded ohms and the mantissa fraction normalized to Q30.
  logic [NUM_W-1:0]    rq;
  logic [63:0]         ow;
  logic [NUM_W+29:0]   wide;
  side_t               sd_n;
  logic                n_v;
  logic [29:0]         n_f;
  logic [PW-1:0]       n_p;
  side_t               n_sd;

  always_comb begin
    rq = d1_nq[NUM_W];
    ow = (64'(rq) + 64'd32768) >> 16;
    wide = {rq, 30'd0} >> d1_p[NUM_W];
    sd_n = d1_sd[NUM_W];
    sd_n.ohms = (ow > 64'hFFFF_FFFF) ? '1 : ow[OHMS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (adv) begin
      n_v <= d1_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_f <= wide[29:0];
      n_p <= d1_p[NUM_W];
      n_sd <= sd_n;
    end
  end

  // Stage I: table index and interpolation weight.
  logic [FD_W-1:0]    fd;
  logic               i_v;
  logic [DEPTH_W-1:0] i_idx;
  logic [29:0]        i_r;
  logic [PW-1:0]      i_p;
  side_t              i_sd;

  assign fd = FD_W'(n_f) * FD_W'(LOG_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (adv) begin
      i_v <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_idx <= fd[FD_W-1:30];
      i_r <= fd[29:0];
      i_p <= n_p;
      i_sd <= n_sd;
    end
  end

  // Stage R: table read of both neighbors.
  logic        r_v;
  logic [30:0] r_lo, r_df;
  logic [29:0] r_r;
  logic [PW-1:0] r_p;
  side_t       r_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (adv) begin
      r_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_lo <= LOG_ROM[i_idx];
      r_df <= LOG_ROM[i_idx + DEPTH_W'(1)] - LOG_ROM[i_idx];
      r_r <= i_r;
      r_p <= i_p;
      r_sd <= i_sd;
    end
  end

  // Stage G: linear interpolation of log2 of the mantissa.
  logic [60:0]   ip;
  logic          g_v;
  logic [30:0]   g_g;
  logic [PW-1:0] g_p;
  side_t         g_sd;

  assign ip = 61'(r_df) * 61'(r_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_g <= r_lo + 31'(ip >> 30);
      g_p <= r_p;
      g_sd <= r_sd;
    end
  end

  // Stage T: both terms of ln in Q30.
  logic [60:0]            lp;
  logic signed [PW:0]     pm;
  logic                   t_v;
  logic [30:0]            t_hi;
  logic signed [LN_W-1:0] t_pw;
  side_t                  t_sd;

  always_comb begin
    lp = 61'(g_g) * 61'(LN2_Q30);
    pm = $signed({1'b0, g_p}) - $signed((PW+1)'(16));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (adv) begin
      t_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_hi <= 31'(lp >> 30);
      t_pw <= LN_W'(pm) * LN2_S;
      t_sd <= g_sd;
    end
  end

  // Stage L: ln to Q16 by magnitude, sign kept aside.
  logic signed [LN_W-1:0] ln30;
  logic [LN_W-1:0]        lnmag;
  logic                   l_v;
  logic [LMAG_W-1:0]      l_lm;
  logic                   l_neg;
  side_t                  l_sd;

  always_comb begin
    ln30 = t_pw + $signed(LN_W'(t_hi));
    lnmag = ln30[LN_W-1] ? LN_W'(-ln30) : LN_W'(ln30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else if (adv) begin
      l_v <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_lm <= LMAG_W'(lnmag >> 14);
      l_neg <= ln30[LN_W-1];
      l_sd <= t_sd;
    end
  end

  // Stage M1: L squared and the two halves of b*L.
  logic        m1_v, m1_neg;
  logic [43:0] m1_sq;
  logic [41:0] m1_bl, m1_bh;
  logic [LMAG_W-1:0] m1_lm;
  side_t       m1_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sq <= 44'(l_lm) * 44'(l_lm);
      m1_bl <= 42'(coef_b[19:0]) * 42'(l_lm);
      m1_bh <= 42'(coef_b[39:20]) * 42'(l_lm);
      m1_lm <= l_lm;
      m1_neg <= l_neg;
      m1_sd <= l_sd;
    end
  end

  // Stage M2: L cubed and the b term.
  logic        m2_v, m2_neg;
  logic [49:0] m2_l3p;
  logic [45:0] m2_bt;
  side_t       m2_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (adv) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_l3p <= 50'(m1_sq[43:16]) * 50'(m1_lm);
      m2_bt <= 46'(((62'(m1_bh) << 20) + 62'(m1_bl)) >> 16);
      m2_neg <= m1_neg;
      m2_sd <= m1_sd;
    end
  end

  // Stage M3: the two halves of c*L^3.
  logic [33:0] l3m;
  logic        m3_v, m3_neg;
  logic [48:0] m3_cl, m3_ch;
  logic [45:0] m3_bt;
  side_t       m3_sd;

  assign l3m = m2_l3p[49:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (adv) begin
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_cl <= 49'(coef_c) * 49'(l3m[16:0]);
      m3_ch <= 49'(coef_c) * 49'(l3m[33:17]);
      m3_bt <= m2_bt;
      m3_neg <= m2_neg;
      m3_sd <= m2_sd;
    end
  end

  // Stage M4: c term.
  logic        m4_v, m4_neg;
  logic [49:0] m4_ct;
  logic [45:0] m4_bt;
  side_t       m4_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else if (adv) begin
      m4_v <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_ct <= 50'(((66'(m3_ch) << 17) + 66'(m3_cl)) >> 16);
      m4_bt <= m3_bt;
      m4_neg <= m3_neg;
      m4_sd <= m3_sd;
    end
  end

  // Stage M5: denominator 1/T in Q48.
  logic signed [DEN_W-1:0] bt_s, ct_s;
  logic                    m5_v;
  logic signed [DEN_W-1:0] m5_den;
  side_t                   m5_sd;

  always_comb begin
    bt_s = $signed(DEN_W'(m4_bt));
    ct_s = $signed(DEN_W'(m4_ct));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_v <= 1'b0;
    end else if (adv) begin
      m5_v <= m4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_den <= $signed(DEN_W'(coef_a)) + (m4_neg ? -bt_s : bt_s)
              + (m4_neg ? -ct_s : ct_s);
      m5_sd <= m4_sd;
    end
  end

  // Temperature divider: stage 0 sets up the rounded numerator and the range check.
  logic              d2_v   [0:Q_W];
  logic [DD_W-1:0]   d2_rem [0:Q_W];
  logic [Q_W-1:0]    d2_low [0:Q_W];
  logic [DD_W-1:0]   d2_dd  [0:Q_W];
  logic              d2_sat [0:Q_W];
  side_t             d2_sd  [0:Q_W];

  logic [DD_W-1:0]   dd;
  logic [N2_W-1:0]   n2;
  logic [N2_W-19:0]  n2_hi;
  logic              den_bad;

  always_comb begin
    dd = DD_W'(m5_den);
    n2 = CENTI_ONE_Q48 + N2_W'(dd >> 1);
    n2_hi = n2[N2_W-1:18];
    den_bad = m5_den[DEN_W-1] || (m5_den == '0) || (DD_W'(n2_hi) >= dd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v[0] <= 1'b0;
    end else if (adv) begin
      d2_v[0] <= m5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_rem[0] <= DD_W'(n2_hi);
      d2_low[0] <= n2[Q_W-1:0];
      d2_dd[0] <= dd;
      d2_sat[0] <= den_bad;
      d2_sd[0] <= m5_sd;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div2
    logic [DD_W:0]   trial;
    logic            ge;
    logic [DD_W-1:0] rem_next;

    always_comb begin
      trial = {d2_rem[k], d2_low[k][Q_W-1]};
      ge = (trial >= {1'b0, d2_dd[k]});
      rem_next = ge ? DD_W'(trial - {1'b0, d2_dd[k]}) : DD_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[k+1] <= 1'b0;
      end else if (adv) begin
        d2_v[k+1] <= d2_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d2_rem[k+1] <= rem_next;
        d2_low[k+1] <= {d2_low[k][Q_W-2:0], ge};
        d2_dd[k+1] <= d2_dd[k];
        d2_sat[k+1] <= d2_sat[k];
        d2_sd[k+1] <= d2_sd[k];
      end
    end
  end

  // Output register: Kelvin to Celsius, saturation and the special cases.
  logic [Q_W-1:0]    kq;
  logic [TEMP_W-1:0] temp_c;
  side_t             fsd;
  logic [TEMP_W-1:0] out_temp;
  logic [OHMS_W-1:0] out_ohms;
  logic              out_inv;

  always_comb begin
    kq = d2_low[Q_W];
    fsd = d2_sd[Q_W];
    if (fsd.inv) begin
      temp_c = '0;
    end else if (d2_sat[Q_W] || kq > KELVIN_MAX) begin
      temp_c = TEMP_MAX;
    end else begin
      temp_c = TEMP_W'(kq - CELSIUS_OFFSET);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= d2_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp <= temp_c;
      out_inv <= fsd.inv;
      if (fsd.inv) begin
        out_ohms <= fsd.full ? '1 : '0;
      end else begin
        out_ohms <= fsd.ohms;
      end
    end
  end

  assign result.valid = out_v;
  assign result.temperature_centi = $signed(out_temp);
  assign result.resistance_ohms = out_ohms;
  assign result.reading_invalid = out_inv;

`ifndef NO_ASSERTIONS
  // The resistance divider leaves a remainder below the divisor for good readings.
  a_div1_rem : assert property (@(posedge clk) disable iff (rst)
    d1_v[NUM_W] && !d1_sd[NUM_W].inv |-> d1_rem[NUM_W] < d1_dv[NUM_W])
    else $error("resistance divider remainder not below divisor");

  // The temperature divider leaves a remainder below the divisor when in range.
  a_div2_rem : assert property (@(posedge clk) disable iff (rst)
    d2_v[Q_W] && !d2_sat[Q_W] |-> d2_rem[Q_W] < d2_dd[Q_W])
    else $error("temperature divider remainder not below divisor");

  // An invalid reading reports zero temperature.
  a_inv_temp : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.reading_invalid |-> result.temperature_centi == '0)
    else $error("invalid reading with nonzero temperature");

  // A valid reading never goes below absolute zero.
  a_temp_floor : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.reading_invalid |->
      result.temperature_centi >= -18'sd27315)
    else $error("temperature below absolute zero");

  // An invalid reading reports resistance as zero or all ones.
  a_inv_ohms : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.reading_invalid |->
      result.resistance_ohms == '0 || result.resistance_ohms == '1)
    else $error("invalid reading with a resistance value");
`endif

endmodule

`default_nettype wire

>>> verif/tb_thermistor_to_temperature_unit.sv
// Testbench for the thermistor converter: random and directed samples checked against a predictor.
`default_nettype none

module tb_thermistor_to_temperature_unit;
  import t2t_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SUM  = 3069;
  localparam int LOG_DEPTH = 256;
  localparam int LATENCY   = 81;
  localparam longint LN2 = 744261118;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [OHMS_W-1:0]        ohms;
    logic                     inv;
  } reading_t;

  // Predicts each reading and keeps the readings still owed by the converter.
  class reading_board;
    reading_t owed[$];
    int mismatches;
    longint unsigned series, ca, cb, cc;
    longint unsigned log_tab[LOG_DEPTH+1];

    function new();
      longint unsigned y, r;
      series = SERIES_RST;
      ca = COEF_A_RST;
      cb = COEF_B_RST;
      cc = COEF_C_RST;
      mismatches = 0;
      // Log2 table by bit-serial squaring.
      for (int i = 0; i <= LOG_DEPTH; i++) begin
        y = (64'd1 << 30) + ((longint'(i) << 30) / LOG_DEPTH);
        r = 0;
        if (y >= (64'd1 << 31)) begin
          r = 64'd1 << 30;
        end else begin
          for (int b = 29; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
              y = y >> 1;
              r = r | (64'd1 << b);
            end
          end
        end
        log_tab[i] = r;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SERIES: series = val[SERIES_W-1:0];
        REG_COEF_A: ca = val[COEF_W-1:0];
        REG_COEF_B: cb = val[COEF_W-1:0];
        REG_COEF_C: cc = val[COEFC_W-1:0];
      endcase
    endfunction

    function longint scale(longint unsigned c, longint v);
      longint unsigned m;
      m = (c * ((v < 0) ? -v : v)) >> 16;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Converts one set of samples into the expected reading.
    function void note_samples(int a, int b, int c);
      reading_t e;
      longint unsigned s, rq, ohms, f, fd, idx, fr, g, lo, hi, k;
      longint ln30, l16, l2, l3, den;
      int p;
      s = 64'(a + b + c);
      e.inv = 0;
      if (s == 0 || s == FULL_SUM) begin
        e.inv = 1;
        e.temp = 0;
        e.ohms = (s == 0) ? 32'd0 : 32'hFFFFFFFF;
        owed.push_back(e);
        return;
      end
      rq = ((series * s) << 16) / (FULL_SUM - s);
      ohms = (rq + 32768) >> 16;
      e.ohms = (ohms > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ohms[31:0];
      if (rq == 0) rq = 1;
      p = 0;
      while (p < 63 && (rq >> (p + 1)) != 0) p++;
      if (p >= 30) f = (rq >> (p - 30)) - (64'd1 << 30);
      else f = (rq << (30 - p)) - (64'd1 << 30);
      fd = f * LOG_DEPTH;
      idx = fd >> 30;
      fr = fd & ((64'd1 << 30) - 1);
      if (idx >= LOG_DEPTH) idx = LOG_DEPTH - 1;
      lo = log_tab[idx];
      hi = log_tab[idx+1];
      g = lo + (((hi - lo) * fr) >> 30);
      ln30 = (longint'(p) - 16) * LN2 + longint'((g * LN2) >> 30);
      l16 = (ln30 < 0) ? -((-ln30) >>> 14) : (ln30 >>> 14);
      l2 = ((l16 < 0 ? -l16 : l16) * (l16 < 0 ? -l16 : l16)) >> 16;
      l3 = scale(l2, l16);
      den = longint'(ca) + scale(cb, l16) + scale(cc, l3);
      if (den <= 0) begin
        e.temp = TEMP_MAX;
      end else begin
        k = ((64'd100 << 48) + (longint'(den) >> 1)) / longint'(den);
        if (k > 131071 + 27315) e.temp = TEMP_MAX;
        else e.temp = TEMP_W'(longint'(k) - 27315);
      end
      owed.push_back(e);
    endfunction

    function void check_reading(reading_t got);
      reading_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading temp=%0d", got.temp);
        return;
      end
      e = owed.pop_front();
      if (got.temp !== e.temp || got.ohms !== e.ohms || got.inv !== e.inv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp temp=%0d ohms=%0d inv=%0b, got temp=%0d ohms=%0d inv=%0b",
                   e.temp, e.ohms, e.inv, got.temp, got.ohms, got.inv);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic hold_off = 0;

  t2t_in_if  samples ();
  t2t_out_if result ();

  reading_board board = new();

  thermistor_to_temperature_unit uut (
    .clk(clk), .rst(rst), .samples(samples), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    samples.valid = 0;
    samples.sample_first = '0;
    samples.sample_second = '0;
    samples.sample_third = '0;
    result.ready = 0;
  end

  // Receiver: stalls on its own pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else if (hold_off) begin
      result.ready <= 0;
    end else begin
      case ($urandom_range(0, 3))
        0: result.ready <= ($urandom_range(0, 9) < 2);
        default: result.ready <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    reading_t got;
    if (!rst && result.valid && result.ready) begin
      got.temp = result.temperature_centi;
      got.ohms = result.resistance_ohms;
      got.inv = result.reading_invalid;
      board.check_reading(got);
    end
  end

  // Offers one set of samples and waits for its transfer.
  task automatic send_samples(int a, int b, int c);
    samples.valid <= 1;
    samples.sample_first <= SAMPLE_W'(a);
    samples.sample_second <= SAMPLE_W'(b);
    samples.sample_third <= SAMPLE_W'(c);
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    board.note_samples(a, b, c);
  endtask

  task automatic idle_input(int n);
    samples.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    samples.valid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    board.set_reg(idx, val);
  endtask

  // Random sample set, biased toward realistic mid-range sums with some extremes.
  task automatic send_random();
    int a, b, c, m;
    m = $urandom_range(0, 19);
    if (m == 0) begin
      a = 1023 * $urandom_range(0, 1);
      b = a;
      c = a;
    end else if (m < 4) begin
      a = $urandom_range(0, 1023);
      b = $urandom_range(0, 1023);
      c = $urandom_range(0, 1023);
    end else begin
      a = $urandom_range(100, 923);
      b = a + $urandom_range(0, 20) - 10;
      c = a + $urandom_range(0, 20) - 10;
    end
    send_samples(a, b, c);
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        send_random();
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 8));
    end
  endtask

  // Main stimulus.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes of each field and both invalid sums.
    send_samples(0, 0, 0);
    send_samples(1023, 1023, 1023);
    send_samples(1, 0, 0);
    send_samples(1023, 1023, 1022);
    send_samples(1023, 0, 0);
    send_samples(0, 1023, 0);
    send_samples(0, 0, 1023);
    send_samples(512, 512, 512);
    send_samples(341, 682, 170);
    send_samples(682, 341, 853);
    send_samples(1000, 1000, 1000);
    send_samples(5, 3, 2);
    drain();
    repeat (LATENCY) @(posedge clk);

    // Extreme settings: tiny resistor, zero coefficients, then all maximums.
    write_reg(REG_SERIES, 1);
    write_reg(REG_COEF_A, 0);
    write_reg(REG_COEF_B, 0);
    write_reg(REG_COEF_C, 0);
    send_samples(1, 0, 0);
    send_samples(1023, 1023, 1022);
    send_samples(700, 300, 12);
    drain();
    repeat (LATENCY) @(posedge clk);
    write_reg(REG_SERIES, 1000000);
    write_reg(REG_COEF_A, 40'hFFFFFFFFFF);
    write_reg(REG_COEF_B, 40'hFFFFFFFFFF);
    write_reg(REG_COEF_C, 40'hFFFFFFFF);
    send_samples(1, 0, 0);
    send_samples(1023, 1023, 1022);
    send_samples(400, 500, 600);
    drain();
    repeat (LATENCY) @(posedge clk);

    // Negative denominator: small constant term with a large linear term.
    write_reg(REG_SERIES, 10000);
    write_reg(REG_COEF_A, 1000);
    write_reg(REG_COEF_B, 40'd500000000000);
    write_reg(REG_COEF_C, 0);
    send_samples(1, 0, 0);
    send_samples(1023, 1023, 1020);
    drain();
    repeat (LATENCY) @(posedge clk);

    // Defaults, with a long receiver hold-off while samples keep coming.
    write_reg(REG_SERIES, CFG_W'(SERIES_RST));
    write_reg(REG_COEF_A, CFG_W'(COEF_A_RST));
    write_reg(REG_COEF_B, CFG_W'(COEF_B_RST));
    write_reg(REG_COEF_C, CFG_W'(COEF_C_RST));
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      random_phase(150);
    join
    drain();
    random_phase(600);
    drain();
    repeat (LATENCY) @(posedge clk);

    // Random registers near realistic values, then fully random ones.
    write_reg(REG_SERIES, CFG_W'($urandom_range(1, 1000000)));
    write_reg(REG_COEF_A, {8'd0, $urandom} + 40'd200000000000);
    write_reg(REG_COEF_B, {8'($urandom_range(0, 30)), $urandom});
    write_reg(REG_COEF_C, CFG_W'($urandom_range(0, 200000000)));
    random_phase(400);
    drain();
    repeat (LATENCY) @(posedge clk);
    write_reg(REG_SERIES, CFG_W'($urandom_range(1, 1000000)));
    write_reg(REG_COEF_A, {8'($urandom_range(0, 255)), $urandom});
    write_reg(REG_COEF_B, {8'($urandom_range(0, 255)), $urandom});
    write_reg(REG_COEF_C, CFG_W'($urandom));
    random_phase(300);
    drain();
    repeat (LATENCY) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/t2t_pkg.sv
sv/t2t_if.sv
sv/thermistor_to_temperature_unit.sv
verif/tb_thermistor_to_temperature_unit.sv
